// File: sv/tlnf_pkg.sv
// ----------------------------------------------------------------------------
// tlnf_pkg
// Shared types, constants and helpers of the text line-number filter.
// ----------------------------------------------------------------------------
package tlnf_pkg;

  localparam int NUMBER_DIGITS = 6;
  localparam int COUNT_W       = 4 * NUMBER_DIGITS;
  localparam int DIGIT_IDX_W   = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_INDEX_W-1:0] REG_NUMBER_MODE      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SQUEEZE_BLANK    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SHOW_TABS        = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SHOW_ENDS        = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SHOW_NONPRINTING = 3'd4;

  localparam logic [1:0] MODE_NONE     = 2'd0;
  localparam logic [1:0] MODE_ALL      = 2'd1;
  localparam logic [1:0] MODE_NONBLANK = 2'd2;

  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_CTRL_END  = 8'd32;
  localparam logic [7:0] CH_SPACE     = 8'd32;
  localparam logic [7:0] CH_DOLLAR    = 8'd36;
  localparam logic [7:0] CH_ZERO      = 8'd48;
  localparam logic [7:0] CH_I         = 8'd73;
  localparam logic [7:0] CH_CARET     = 8'd94;
  localparam logic [7:0] CH_TILDE     = 8'd126;
  localparam logic [7:0] CH_HIGH_END  = 8'd160;
  localparam logic [7:0] CARET_OFFSET = 8'd64;

  typedef struct packed {
    logic [1:0] number_mode;
    logic       squeeze_blank;
    logic       show_tabs;
    logic       show_ends;
    logic       show_nonprinting;
  } cfg_t;

  typedef struct packed {
    logic               numbered;
    logic [COUNT_W-1:0] digits;
    logic               pre_en;
    logic [7:0]         pre_char;
    logic [7:0]         ch;
  } cmd_t;

  typedef enum logic [1:0] {
    PH_DIGIT,
    PH_TAB,
    PH_PRE,
    PH_CHAR
  } phase_t;

  function automatic logic [COUNT_W-1:0] bcd_inc(input logic [COUNT_W-1:0] v);
    logic [COUNT_W-1:0] r;
    logic               carry;
    logic               sat;
    logic [3:0]         d;
    r     = v;
    carry = 1'b1;
    sat   = 1'b1;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      d = v[4*i +: 4];
      if (d != 4'd9) sat = 1'b0;
      if (carry) begin
        if (d < 4'd9) begin
          r[4*i +: 4] = d + 4'd1;
          carry       = 1'b0;
        end else begin
          r[4*i +: 4] = 4'd0;
        end
      end
    end
    return sat ? v : r;
  endfunction

endpackage

// File: sv/tlnf_front.sv
// ----------------------------------------------------------------------------
// tlnf_front
// Accepts input bytes, tracks line state and the BCD line count, and turns
// each byte that is not squeezed into one output command.
// ----------------------------------------------------------------------------
module tlnf_front (
  input  logic                         clk,
  input  logic                         rst,
  input  tlnf_pkg::cfg_t               cfg,
  input  logic                         push,
  input  logic [7:0]                   data_byte,
  input  logic                         start_of_file,
  input  logic                         queue_full,
  output logic                         cmd_push,
  output tlnf_pkg::cmd_t               cmd
);
  import tlnf_pkg::*;

  logic               prev_newline, prev_newline_next;
  logic [1:0]         blank_run, blank_run_next;
  logic [COUNT_W-1:0] line_count, line_count_next;

  logic               accept;
  logic               nl;
  logic               pn;
  logic [1:0]         br;
  logic [COUNT_W-1:0] cnt;
  logic               squeezed;
  logic               numbered;
  logic               ctrl;

  assign accept = push && !queue_full;
  assign nl     = (data_byte == CH_NEWLINE);
  assign ctrl   = (data_byte < CH_TAB) ||
                  (data_byte > CH_NEWLINE && data_byte < CH_CTRL_END) ||
                  (data_byte > CH_TILDE && data_byte <= CH_HIGH_END);

  always_comb begin
    pn  = start_of_file ? 1'b1 : prev_newline;
    br  = start_of_file ? 2'd0 : blank_run;
    cnt = start_of_file ? COUNT_W'(1) : line_count;

    squeezed       = 1'b0;
    blank_run_next = 2'd0;
    if (cfg.squeeze_blank && nl && pn) begin
      blank_run_next = (br < 2'd2) ? br + 2'd1 : br;
      squeezed       = (blank_run_next > 2'd1);
    end

    numbered = !squeezed && pn && (cfg.number_mode == MODE_ALL ||
                                   (cfg.number_mode >= MODE_NONBLANK && !nl));
    line_count_next   = numbered ? bcd_inc(cnt) : cnt;
    prev_newline_next = nl;

    cmd.numbered = numbered;
    cmd.digits   = cnt;
    cmd.pre_en   = 1'b0;
    cmd.pre_char = CH_CARET;
    cmd.ch       = data_byte;
    if (cfg.show_tabs && data_byte == CH_TAB) begin
      cmd.pre_en = 1'b1;
      cmd.ch     = CH_I;
    end else if (cfg.show_ends && nl) begin
      cmd.pre_en   = 1'b1;
      cmd.pre_char = CH_DOLLAR;
    end else if (cfg.show_nonprinting && ctrl) begin
      cmd.pre_en = 1'b1;
      cmd.ch     = (data_byte > CH_TILDE) ? data_byte - CARET_OFFSET
                                          : data_byte + CARET_OFFSET;
    end

    cmd_push = accept && !squeezed;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_newline <= 1'b1;
      blank_run    <= 2'd0;
      line_count   <= COUNT_W'(1);
    end else if (accept) begin
      prev_newline <= prev_newline_next;
      blank_run    <= blank_run_next;
      line_count   <= line_count_next;
    end
  end

endmodule

// File: sv/tlnf_queue.sv
// ----------------------------------------------------------------------------
// tlnf_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module tlnf_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tlnf_pkg::cmd_t push_cmd,
  output logic           full,
  output logic           valid,
  output tlnf_pkg::cmd_t head,
  input  logic           pop
);
  import tlnf_pkg::*;

  cmd_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign valid   = (count != '0);
  assign head    = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      count <= count + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end
  end

endmodule

// File: sv/tlnf_back.sv
// ----------------------------------------------------------------------------
// tlnf_back
// Expands each command into its run of output bytes and holds the next byte
// in an output register.
// ----------------------------------------------------------------------------
module tlnf_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  tlnf_pkg::cmd_t head,
  output logic           head_pop,
  output logic [7:0]     out_byte,
  output logic           last_of_run,
  output logic           empty,
  input  logic           pop
);
  import tlnf_pkg::*;

  logic                   mid;
  phase_t                 phase;
  logic [DIGIT_IDX_W-1:0] didx;
  logic                   lead;
  logic                   out_valid;

  logic                   mid_next;
  phase_t                 phase_next;
  logic [DIGIT_IDX_W-1:0] didx_next;
  logic                   lead_next;

  phase_t                 ph;
  logic [DIGIT_IDX_W-1:0] di;
  logic                   ld;
  logic [NUMBER_DIGITS-1:0][3:0] digit_arr;
  logic [3:0]             d;
  logic                   blank;
  logic                   emit;
  logic [7:0]             byte_next;
  logic                   last_next;
  phase_t                 after_num;

  assign digit_arr = head.digits;
  assign empty     = !out_valid;
  assign emit      = head_valid && (!out_valid || pop);
  assign after_num = head.pre_en ? PH_PRE : PH_CHAR;

  always_comb begin
    if (mid) begin
      ph = phase;
      di = didx;
      ld = lead;
    end else begin
      ph = head.numbered ? PH_DIGIT : after_num;
      di = DIGIT_IDX_W'(NUMBER_DIGITS - 1);
      ld = 1'b1;
    end

    d     = digit_arr[di];
    blank = ld && (d == 4'd0) && (di != '0);

    mid_next   = 1'b1;
    phase_next = ph;
    didx_next  = di;
    lead_next  = ld;
    byte_next  = head.ch;
    last_next  = 1'b0;
    head_pop   = 1'b0;

    case (ph)
      PH_DIGIT: begin
        byte_next = blank ? CH_SPACE : (CH_ZERO + {4'd0, d});
        lead_next = blank;
        if (di == '0) phase_next = PH_TAB;
        else          didx_next  = di - DIGIT_IDX_W'(1);
      end
      PH_TAB: begin
        byte_next  = CH_TAB;
        phase_next = after_num;
      end
      PH_PRE: begin
        byte_next  = head.pre_char;
        phase_next = PH_CHAR;
      end
      PH_CHAR: begin
        byte_next = head.ch;
        last_next = 1'b1;
        mid_next  = 1'b0;
        head_pop  = emit;
      end
      default: begin
        mid_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid       <= 1'b0;
      phase     <= PH_CHAR;
      didx      <= '0;
      lead      <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        mid       <= mid_next;
        phase     <= phase_next;
        didx      <= didx_next;
        lead      <= lead_next;
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte    <= byte_next;
      last_of_run <= last_next;
    end
  end

endmodule

// File: sv/text_line_number_filter_unit.sv
// ----------------------------------------------------------------------------
// text_line_number_filter_unit
// Byte-stream formatter with line numbering, blank squeezing and caret forms.
// ----------------------------------------------------------------------------
// Each pushed byte yields one to nine output bytes (a six-digit number and a
// tab, a caret or dollar prefix, then the byte); a squeezed blank line yields
// none. The front takes one byte a cycle while its four-entry command queue
// has room; the back emits one output byte a cycle while the output is popped,
// so plain text streams at one byte per cycle. The first output byte passes
// through the command queue and the back's output register before it is on
// the ports.
// ----------------------------------------------------------------------------
module text_line_number_filter_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [tlnf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tlnf_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             push,
  output logic                             full,
  input  logic [7:0]                       data_byte,
  input  logic                             start_of_file,
  output logic                             empty,
  input  logic                             pop,
  output logic [7:0]                       out_byte,
  output logic                             last_of_run
);
  import tlnf_pkg::*;

  cfg_t cfg;
  cmd_t front_cmd;
  cmd_t head_cmd;
  logic front_push;
  logic head_valid;
  logic head_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUMBER_MODE:      cfg.number_mode      <= cfg_data;
        REG_SQUEEZE_BLANK:    cfg.squeeze_blank    <= cfg_data[0];
        REG_SHOW_TABS:        cfg.show_tabs        <= cfg_data[0];
        REG_SHOW_ENDS:        cfg.show_ends        <= cfg_data[0];
        REG_SHOW_NONPRINTING: cfg.show_nonprinting <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  tlnf_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .push          (push),
    .data_byte     (data_byte),
    .start_of_file (start_of_file),
    .queue_full    (full),
    .cmd_push      (front_push),
    .cmd           (front_cmd)
  );

  tlnf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (front_push),
    .push_cmd (front_cmd),
    .full     (full),
    .valid    (head_valid),
    .head     (head_cmd),
    .pop      (head_pop)
  );

  tlnf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head        (head_cmd),
    .head_pop    (head_pop),
    .out_byte    (out_byte),
    .last_of_run (last_of_run),
    .empty       (empty),
    .pop         (pop)
  );

endmodule
